/* rtl/tmcd_pkg.sv */
// ----------------------------------------------------------------------------
// tmcd_pkg
// Shared constants and types of the tile map cell decoder.
// ----------------------------------------------------------------------------
package tmcd_pkg;

  localparam int MAX_TILESETS    = 8;
  localparam int SLOT_BITS       = 3;
  localparam int CELL_INDEX_BITS = 16;
  localparam int DIV_BITS        = 16;
  localparam int DIVISOR_BITS    = 11;

  localparam logic [1:0] ST_LOADED  = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_PLACED  = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_270  = 2'd2;

  localparam logic       OP_LOAD   = 1'b0;
  localparam logic       OP_DECODE = 1'b1;

  localparam logic [1:0] REG_MAP_WIDTH     = 2'd0;
  localparam logic [1:0] REG_TILE_WIDTH    = 2'd1;
  localparam logic [1:0] REG_TILE_HEIGHT   = 2'd2;
  localparam logic [1:0] REG_TILESET_COUNT = 2'd3;

  // word carried through the divider stages
  typedef struct packed {
    logic [1:0]              status;
    logic [SLOT_BITS-1:0]    hit;
    logic                    flipped;
    logic [1:0]              rot;
    logic                    mx;
    logic                    my;
    logic [DIV_BITS-1:0]     tnum;   // tile id, becomes quotient
    logic [DIVISOR_BITS-1:0] trem;
    logic [DIVISOR_BITS-1:0] tcols;
    logic [DIV_BITS-1:0]     cnum;   // cell index, becomes quotient
    logic [DIVISOR_BITS-1:0] crem;
    logic [DIVISOR_BITS-1:0] mw;
  } div_word_t;

  typedef struct packed {
    logic [8:0] tile_width;
    logic [8:0] tile_height;
  } tile_size_t;

endpackage

/* rtl/tmcd_search.sv */
// ----------------------------------------------------------------------------
// tmcd_search
// Input register, tileset table and first-match search stage.
// ----------------------------------------------------------------------------
module tmcd_search (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic                            op,
  input  logic [2:0]                      slot,
  input  logic [27:0]                     first_id,
  input  logic [15:0]                     tile_count,
  input  logic [10:0]                     columns,
  input  logic [31:0]                     raw_cell,
  input  logic [15:0]                     cell_index,
  input  logic [10:0]                     map_width,
  input  logic [3:0]                      tileset_count,
  output logic                            out_valid,
  output tmcd_pkg::div_word_t             out_word
);
  import tmcd_pkg::*;

  logic [27:0] tab_first [MAX_TILESETS];
  logic [15:0] tab_size  [MAX_TILESETS];
  logic [10:0] tab_cols  [MAX_TILESETS];

  logic        s1_valid;
  logic        s1_op;
  logic [31:0] s1_raw;
  logic [15:0] s1_cell;

  logic [28:0] id;
  logic [28:0] diff [MAX_TILESETS];
  logic [MAX_TILESETS-1:0] match;
  logic        found;
  logic [SLOT_BITS-1:0] hit;
  logic [3:0]  limit;
  logic        h, v, d;
  div_word_t   w;

  always_ff @(posedge clk) begin
    if (in_valid && adv && op == OP_LOAD && int'(slot) < MAX_TILESETS) begin
      tab_first[slot] <= first_id;
      tab_size[slot]  <= tile_count;
      tab_cols[slot]  <= columns;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      s1_op   <= op;
      s1_raw  <= raw_cell;
      s1_cell <= cell_index;
    end
  end

  always_comb begin
    id    = s1_raw[28:0];
    limit = (tileset_count < 4'(MAX_TILESETS)) ? tileset_count : 4'(MAX_TILESETS);
    for (int i = 0; i < MAX_TILESETS; i++) begin
      diff[i]  = id - {1'b0, tab_first[i]};
      match[i] = (4'(i) < limit) && (id >= {1'b0, tab_first[i]}) &&
                 (diff[i] < {13'd0, tab_size[i]});
    end
    found = |match;
    hit   = '0;
    for (int i = MAX_TILESETS - 1; i >= 0; i--) begin
      if (match[i]) hit = SLOT_BITS'(i);
    end
    h = s1_raw[31];
    v = s1_raw[30];
    d = s1_raw[29];

    w = '0;
    if (s1_op == OP_LOAD)     w.status = ST_LOADED;
    else if (id == '0)        w.status = ST_EMPTY;
    else if (!found)          w.status = ST_NOMATCH;
    else                      w.status = ST_PLACED;
    w.hit     = hit;
    w.flipped = h | v | d;
    // eight-way flip table
    case ({h, v, d})
      3'b100:  begin w.mx = 1'b1; end
      3'b010:  begin w.my = 1'b1; end
      3'b110:  begin w.mx = 1'b1; w.my = 1'b1; end
      3'b001:  begin w.rot = ROT_270; w.mx = 1'b1; end
      3'b101:  begin w.rot = ROT_90; end
      3'b011:  begin w.rot = ROT_270; end
      3'b111:  begin w.rot = ROT_270; w.my = 1'b1; end
      default: begin w.rot = ROT_NONE; end
    endcase
    w.tnum  = diff[hit][DIV_BITS-1:0];
    w.tcols = (tab_cols[hit] == '0) ? 11'd1 : tab_cols[hit];
    w.cnum  = s1_cell[CELL_INDEX_BITS-1:0];
    w.mw    = (map_width == '0) ? 11'd1 : map_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
    if (adv) begin
      out_word <= w;
    end
  end

endmodule

/* rtl/tmcd_div_stage.sv */
// ----------------------------------------------------------------------------
// tmcd_div_stage
// One restoring division step for tile id and cell index, registered.
// ----------------------------------------------------------------------------
module tmcd_div_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  tmcd_pkg::div_word_t in_word,
  output logic                out_valid,
  output tmcd_pkg::div_word_t out_word
);
  import tmcd_pkg::*;

  logic [DIVISOR_BITS:0] trial_t, trial_c;
  logic                  qt, qc;
  div_word_t             w;

  always_comb begin
    w       = in_word;
    trial_t = {in_word.trem, in_word.tnum[DIV_BITS-1]};
    trial_c = {in_word.crem, in_word.cnum[DIV_BITS-1]};
    qt      = trial_t >= {1'b0, in_word.tcols};
    qc      = trial_c >= {1'b0, in_word.mw};
    w.trem  = qt ? DIVISOR_BITS'(trial_t - {1'b0, in_word.tcols})
                 : trial_t[DIVISOR_BITS-1:0];
    w.crem  = qc ? DIVISOR_BITS'(trial_c - {1'b0, in_word.mw})
                 : trial_c[DIVISOR_BITS-1:0];
    w.tnum  = {in_word.tnum[DIV_BITS-2:0], qt};
    w.cnum  = {in_word.cnum[DIV_BITS-2:0], qc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_word <= w;
    end
  end

endmodule

/* rtl/tmcd_out.sv */
// ----------------------------------------------------------------------------
// tmcd_out
// Scaling multiplies, half-tile offset and output register.
// ----------------------------------------------------------------------------
module tmcd_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  tmcd_pkg::div_word_t  in_word,
  input  tmcd_pkg::tile_size_t tsize,
  output logic                 out_valid,
  output logic [1:0]           status,
  output logic [2:0]           tileset_index,
  output logic [17:0]          src_x,
  output logic [23:0]          src_y,
  output logic [19:0]          dst_x_half,
  output logic [24:0]          dst_y_half,
  output logic [1:0]           rotation,
  output logic                 mirror_x,
  output logic                 mirror_y
);
  import tmcd_pkg::*;

  logic        m_valid;
  div_word_t   m_word;
  logic [17:0] m_sx;
  logic [23:0] m_sy;
  logic [19:0] m_dx;
  logic [24:0] m_dy;
  logic        placed;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= in_valid;
    end
    if (adv) begin
      m_word <= in_word;
      m_sx   <= 18'({9'd0, in_word.trem} * {11'd0, tsize.tile_width});
      m_sy   <= 24'({9'd0, in_word.tnum} * {16'd0, tsize.tile_height});
      m_dx   <= 20'({8'd0, in_word.crem, 1'b0} * {11'd0, tsize.tile_width});
      m_dy   <= 25'({8'd0, in_word.cnum, 1'b0} * {16'd0, tsize.tile_height});
    end
  end

  assign placed = (m_word.status == ST_PLACED);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= m_valid;
    end
    if (adv) begin
      status        <= m_word.status;
      tileset_index <= placed ? m_word.hit : '0;
      src_x         <= placed ? m_sx : '0;
      src_y         <= placed ? m_sy : '0;
      // flipped tiles are placed by their center
      dst_x_half    <= placed ? 20'(m_dx + (m_word.flipped ? {11'd0, tsize.tile_width} : 20'd0))
                              : '0;
      dst_y_half    <= placed ? 25'(m_dy + (m_word.flipped ? {16'd0, tsize.tile_height} : 25'd0))
                              : '0;
      rotation      <= placed ? m_word.rot : ROT_NONE;
      mirror_x      <= placed & m_word.mx;
      mirror_y      <= placed & m_word.my;
    end
  end

endmodule

/* rtl/tile_map_cell_decoder.sv */
// ----------------------------------------------------------------------------
// tile_map_cell_decoder
// Tileset table load and map cell decode, fully pipelined.
// ----------------------------------------------------------------------------
// One word is accepted per cycle while the output is free or being taken;
// each word gives one result word after passing the input register, table
// search, 16 division steps that yield tile row/column and map row/column,
// a multiply stage and the output register. A stalled output freezes the
// whole pipeline. A load updates the table at its accept edge, so a decode
// accepted right after it already sees the new entry.
module tile_map_cell_decoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [10:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot, first_id, tile_count, columns, raw_cell, cell_index
  input  logic [111:0] s_tdata,
  // op
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tileset_index, src_x, src_y, dst_x_half, dst_y_half, rotation,
  // mirror_x, mirror_y
  output logic [95:0]  m_tdata,
  // status
  output logic [1:0]   m_tuser
);
  import tmcd_pkg::*;

  logic [10:0] map_width;
  logic [3:0]  tileset_count;
  tile_size_t  tsize;
  logic        adv;

  logic      v_pipe [DIV_BITS+1];
  div_word_t w_pipe [DIV_BITS+1];

  logic [2:0]  tileset_index;
  logic [17:0] src_x;
  logic [23:0] src_y;
  logic [19:0] dst_x_half;
  logic [24:0] dst_y_half;
  logic [1:0]  rotation;
  logic        mirror_x, mirror_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width         <= 11'd1;
      tsize.tile_width  <= 9'd32;
      tsize.tile_height <= 9'd32;
      tileset_count     <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:     map_width         <= cfg_data;
        REG_TILE_WIDTH:    tsize.tile_width  <= cfg_data[8:0];
        REG_TILE_HEIGHT:   tsize.tile_height <= cfg_data[8:0];
        REG_TILESET_COUNT: tileset_count     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  tmcd_search u_search (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s_tvalid), .op(s_tuser),
    .slot(s_tdata[2:0]), .first_id(s_tdata[30:3]), .tile_count(s_tdata[46:31]),
    .columns(s_tdata[57:47]), .raw_cell(s_tdata[89:58]),
    .cell_index(s_tdata[105:90]), .map_width(map_width),
    .tileset_count(tileset_count), .out_valid(v_pipe[0]), .out_word(w_pipe[0])
  );

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    tmcd_div_stage u_stage (
      .clk(clk), .rst(rst), .adv(adv),
      .in_valid(v_pipe[k]), .in_word(w_pipe[k]),
      .out_valid(v_pipe[k+1]), .out_word(w_pipe[k+1])
    );
  end

  tmcd_out u_out (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(v_pipe[DIV_BITS]), .in_word(w_pipe[DIV_BITS]), .tsize(tsize),
    .out_valid(m_tvalid), .status(m_tuser), .tileset_index(tileset_index),
    .src_x(src_x), .src_y(src_y), .dst_x_half(dst_x_half),
    .dst_y_half(dst_y_half), .rotation(rotation),
    .mirror_x(mirror_x), .mirror_y(mirror_y)
  );

  assign m_tdata = {2'b00, mirror_y, mirror_x, rotation, dst_y_half, dst_x_half,
                    src_y, src_x, tileset_index};

endmodule
